>>> design/qte_pkg.sv
// Shared widths, codes and types for the quintic trajectory evaluator.
// No dependencies; used by qte_horner_step and quintic_trajectory_evaluator.
`default_nettype none

package qte_pkg;

	// Field widths
	localparam int SAMPLE_W = 32;   // signed Q16.16 sample time
	localparam int TIME_W   = 31;   // clamped time, unsigned Q15.16
	localparam int T_FRAC   = 16;   // fraction bits of time
	localparam int COEF_W   = 48;   // Q16.32 coefficients and results

	// Horner datapath widths
	localparam int ACC_W      = 56;                        // accumulator magnitude
	localparam int MAG_SPLIT  = 32;                        // low 32 bits of the magnitude
	localparam int HI_W       = ACC_W - MAG_SPLIT + TIME_W; // high partial product
	localparam int LO_W       = MAG_SPLIT + TIME_W;         // low partial product
	localparam int PROD_W     = 58;                        // capped product magnitude
	localparam int HI_CAP_BIT = PROD_W - 1 - T_FRAC;       // high product overflow bit
	localparam int SUM_W      = 60;                        // product plus term

	localparam int LANES = 4;   // position, velocity, acceleration, jerk
	localparam int STEPS = 5;   // Horner steps per lane

	localparam int LANE_POS  = 0;
	localparam int LANE_VEL  = 1;
	localparam int LANE_ACC  = 2;
	localparam int LANE_JERK = 3;

	// Configuration port
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int REG_SHIFT = 3;
	localparam int REG_IDX_W = ADDR_W - REG_SHIFT;

	localparam logic [REG_IDX_W-1:0] REG_C0       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_C1       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_C2       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_C3       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_C4       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_C5       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DURATION = 3'd6;

	// Phase codes
	localparam logic [1:0] PHASE_BEFORE = 2'd0;
	localparam logic [1:0] PHASE_MOVING = 2'd1;
	localparam logic [1:0] PHASE_DONE   = 2'd2;

	// Saturation limits
	localparam logic [ACC_W-1:0]  MAG_LIMIT = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [ACC_W-1:0]  MAG_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [PROD_W-1:0] PROD_CAP  = {2'b01, {(PROD_W-2){1'b0}}};
	localparam logic signed [SUM_W-1:0] INNER_MAX =
		{{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] INNER_MIN = ~INNER_MAX;

	// Accumulator in sign and magnitude form
	typedef struct packed {
		logic             neg;
		logic [ACC_W-1:0] mag;
	} lane_acc_t;

	// One item on its way through the Horner steps
	typedef struct packed {
		logic [TIME_W-1:0]           t;
		logic [1:0]                  phase;
		lane_acc_t [LANES-1:0]       acc;
	} item_t;

	typedef logic signed [ACC_W-1:0] term_t;
	typedef term_t [LANES-1:0]       lane_terms_t;

endpackage

`default_nettype wire

>>> design/quintic_trajectory_evaluator.sv
// Quintic trajectory evaluator top level: register file, time clamp,
// five Horner steps (qte_horner_step) and saturating output register. Uses qte_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  sample   | sample_valid/sample_stall | sample_time
//  result   | result_valid/result_stall | position, velocity, acceleration, jerk, phase
//  config   | psel/penable/pwrite       | paddr, pwdata, prdata (8 byte stride)
//
// One transfer per cycle on the sample and result channels while neither side stalls;
// the pipeline has one clamp stage, three stages in each of the five Horner steps and one output stage.
// The 24 x 31 and 32 x 31 partial product multipliers set the stage depth.
// Reset clears the register file, the scaled terms and all valid bits; the pipeline is empty after it.
// A stall at the output holds the output register; earlier stages keep filling
// bubbles, and sample_stall rises only when every stage is full.
`default_nettype none

module quintic_trajectory_evaluator import qte_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ADDR_W-1:0]          paddr,
	input  wire logic [DATA_W-1:0]          pwdata,
	output logic      [DATA_W-1:0]          prdata,
	output logic                            pready,
	// samples
	input  wire logic                       sample_valid,
	output logic                            sample_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_time,
	// results
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic signed [COEF_W-1:0]        position,
	output logic signed [COEF_W-1:0]        velocity,
	output logic signed [COEF_W-1:0]        acceleration,
	output logic signed [COEF_W-1:0]        jerk,
	output logic [1:0]                      phase
);

	logic signed [COEF_W-1:0] coef_q [6];
	logic [TIME_W-1:0]        duration_q;
	lane_terms_t              terms_q [STEPS];
	term_t                    coef_x [6];

	logic                     cfg_write;
	logic [REG_IDX_W-1:0]     reg_idx;

	logic                     valid_s1;
	item_t                    item_s1;
	item_t                    clamp_d;
	logic                     ld_s1;

	logic [STEPS:0]           chain_valid;
	logic [STEPS:0]           chain_ready;
	item_t                    chain_item [STEPS+1];

	logic                     ld_out;
	logic                     result_valid_q;
	logic signed [COEF_W-1:0] position_q, velocity_q, acceleration_q, jerk_q;
	logic [1:0]               phase_q;

	// Saturate a sign and magnitude accumulator to 48 bit signed
	function automatic logic signed [COEF_W-1:0] sat_out(input lane_acc_t a);
		logic [ACC_W-1:0] n;
		logic [ACC_W-1:0] lim;
		n   = -a.mag;
		lim = {{(ACC_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};
		if (a.neg) begin
			if (a.mag > lim) return {1'b1, {(COEF_W-1){1'b0}}};
			return n[COEF_W-1:0];
		end
		if (a.mag >= lim) return {1'b0, {(COEF_W-1){1'b1}}};
		return a.mag[COEF_W-1:0];
	endfunction

	// Register file writes
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[ADDR_W-1:REG_SHIFT];
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) coef_q[i] <= '0;
			duration_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_C0:       coef_q[0] <= pwdata[COEF_W-1:0];
				REG_C1:       coef_q[1] <= pwdata[COEF_W-1:0];
				REG_C2:       coef_q[2] <= pwdata[COEF_W-1:0];
				REG_C3:       coef_q[3] <= pwdata[COEF_W-1:0];
				REG_C4:       coef_q[4] <= pwdata[COEF_W-1:0];
				REG_C5:       coef_q[5] <= pwdata[COEF_W-1:0];
				REG_DURATION: duration_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Register file reads
	always_comb begin
		case (reg_idx)
			REG_C0:       prdata = DATA_W'(coef_q[0]);
			REG_C1:       prdata = DATA_W'(coef_q[1]);
			REG_C2:       prdata = DATA_W'(coef_q[2]);
			REG_C3:       prdata = DATA_W'(coef_q[3]);
			REG_C4:       prdata = DATA_W'(coef_q[4]);
			REG_C5:       prdata = DATA_W'(coef_q[5]);
			REG_DURATION: prdata = {{(DATA_W-TIME_W){1'b0}}, duration_q};
			default:      prdata = '0;
		endcase
	end

	// Scale the coefficients by the derivative factors, one set per step
	always_comb begin
		for (int i = 0; i < 6; i++) coef_x[i] = ACC_W'(coef_q[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STEPS; s++) terms_q[s] <= '0;
		end else begin
			terms_q[0][LANE_POS]  <= coef_x[4];
			terms_q[0][LANE_VEL]  <= (coef_x[5] <<< 2) + coef_x[5];
			terms_q[0][LANE_ACC]  <= '0;
			terms_q[0][LANE_JERK] <= '0;

			terms_q[1][LANE_POS]  <= coef_x[3];
			terms_q[1][LANE_VEL]  <= coef_x[4] <<< 2;
			terms_q[1][LANE_ACC]  <= (coef_x[5] <<< 4) + (coef_x[5] <<< 2);
			terms_q[1][LANE_JERK] <= '0;

			terms_q[2][LANE_POS]  <= coef_x[2];
			terms_q[2][LANE_VEL]  <= (coef_x[3] <<< 1) + coef_x[3];
			terms_q[2][LANE_ACC]  <= (coef_x[4] <<< 3) + (coef_x[4] <<< 2);
			terms_q[2][LANE_JERK] <= (coef_x[5] <<< 6) - (coef_x[5] <<< 2);

			terms_q[3][LANE_POS]  <= coef_x[1];
			terms_q[3][LANE_VEL]  <= coef_x[2] <<< 1;
			terms_q[3][LANE_ACC]  <= (coef_x[3] <<< 2) + (coef_x[3] <<< 1);
			terms_q[3][LANE_JERK] <= (coef_x[4] <<< 4) + (coef_x[4] <<< 3);

			terms_q[4][LANE_POS]  <= coef_x[0];
			terms_q[4][LANE_VEL]  <= coef_x[1];
			terms_q[4][LANE_ACC]  <= coef_x[2] <<< 1;
			terms_q[4][LANE_JERK] <= (coef_x[3] <<< 2) + (coef_x[3] <<< 1);
		end
	end

	// Clamp the sample time and seed the accumulators; position starts at c5
	always_comb begin
		logic late;
		late = $signed({sample_time[SAMPLE_W-1], sample_time})
			>= $signed({2'b00, duration_q});
		clamp_d = '0;
		if (late) begin
			clamp_d.t     = duration_q;
			clamp_d.phase = PHASE_DONE;
		end else if (sample_time[SAMPLE_W-1]) begin
			clamp_d.t     = '0;
			clamp_d.phase = PHASE_BEFORE;
		end else begin
			clamp_d.t     = sample_time[TIME_W-1:0];
			clamp_d.phase = PHASE_MOVING;
		end
		clamp_d.acc[LANE_POS].neg = coef_q[5][COEF_W-1];
		clamp_d.acc[LANE_POS].mag = coef_q[5][COEF_W-1] ? -coef_x[5] : coef_x[5];
	end

	assign ld_s1        = !valid_s1 || chain_ready[0];
	assign sample_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && sample_valid) begin
			item_s1 <= clamp_d;
		end
	end

	// Horner steps
	assign chain_valid[0] = valid_s1;
	assign chain_item[0]  = item_s1;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		qte_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_item   (chain_item[g]),
			.terms     (terms_q[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_item  (chain_item[g+1])
		);
	end

	// Output register: saturate to 48 bits and hold while stalled
	assign ld_out             = !result_valid_q || !result_stall;
	assign chain_ready[STEPS] = ld_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ld_out) begin
			result_valid_q <= chain_valid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && chain_valid[STEPS]) begin
			position_q     <= sat_out(chain_item[STEPS].acc[LANE_POS]);
			velocity_q     <= sat_out(chain_item[STEPS].acc[LANE_VEL]);
			acceleration_q <= sat_out(chain_item[STEPS].acc[LANE_ACC]);
			jerk_q         <= sat_out(chain_item[STEPS].acc[LANE_JERK]);
			phase_q        <= chain_item[STEPS].phase;
		end
	end

	assign result_valid = result_valid_q;
	assign position     = position_q;
	assign velocity     = velocity_q;
	assign acceleration = acceleration_q;
	assign jerk         = jerk_q;
	assign phase        = phase_q;

	// Clamp stage agrees with its phase code
	a_before_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.phase == PHASE_BEFORE) |-> (item_s1.t == '0))
		else $error("phase before start with nonzero time");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.phase == PHASE_DONE) |-> (item_s1.t == duration_q))
		else $error("phase done not clamped to duration");

	a_moving_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.phase == PHASE_MOVING) |-> (item_s1.t < duration_q))
		else $error("phase moving outside the interval");

	// An empty output register never back-pressures the input
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled with empty output");

endmodule

`default_nettype wire

>>> design/qte_horner_step.sv
// One Horner step, acc = acc * t + term, for all four lanes in three stages.
// Depends on qte_pkg for widths, limits and the item type.
`default_nettype none

module qte_horner_step import qte_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire item_t       in_item,
	input  wire lane_terms_t terms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output item_t            out_item
);

	logic valid_s1, valid_s2, valid_s3;
	logic ld1, ld2, ld3;

	logic [TIME_W-1:0] t_s1, t_s2;
	logic [1:0]        phase_s1, phase_s2;
	logic [LANES-1:0]  neg_s1, neg_s2;
	logic [HI_W-1:0]   hi_s1 [LANES];
	logic [LO_W-1:0]   lo_s1 [LANES];
	logic [PROD_W-1:0] m_s2 [LANES];
	item_t             item_s3;

	logic [HI_W-1:0]   hi_d [LANES];
	logic [LO_W-1:0]   lo_d [LANES];
	logic [PROD_W-1:0] m_d [LANES];
	lane_acc_t         acc_d [LANES];

	logic caps_ok, mags_ok;

	// Advance a stage when it is empty or its content moves on
	assign ld3      = !valid_s3 || out_ready;
	assign ld2      = !valid_s2 || ld3;
	assign ld1      = !valid_s1 || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= in_valid;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: split the magnitude and form both partial products
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			hi_d[l] = HI_W'(in_item.acc[l].mag[ACC_W-1:MAG_SPLIT]) * HI_W'(in_item.t);
			lo_d[l] = LO_W'(in_item.acc[l].mag[MAG_SPLIT-1:0]) * LO_W'(in_item.t);
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			t_s1     <= in_item.t;
			phase_s1 <= in_item.phase;
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= in_item.acc[l].neg;
				hi_s1[l]  <= hi_d[l];
				lo_s1[l]  <= lo_d[l];
			end
		end
	end

	// Stage 2: join the partials, round half away from zero, cap the magnitude
	always_comb begin
		logic [PROD_W-1:0] rnd;
		rnd = '0;
		for (int l = 0; l < LANES; l++) begin
			rnd = PROD_W'({hi_s1[l][HI_CAP_BIT-1:0], {T_FRAC{1'b0}}})
				+ PROD_W'(lo_s1[l][LO_W-1:T_FRAC])
				+ PROD_W'(lo_s1[l][T_FRAC-1]);
			if (|hi_s1[l][HI_W-1:HI_CAP_BIT]) begin
				m_d[l] = PROD_CAP;
			end else if (rnd > PROD_CAP) begin
				m_d[l] = PROD_CAP;
			end else begin
				m_d[l] = rnd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && valid_s1) begin
			t_s2     <= t_s1;
			phase_s2 <= phase_s1;
			neg_s2   <= neg_s1;
			for (int l = 0; l < LANES; l++) begin
				m_s2[l] <= m_d[l];
			end
		end
	end

	// Stage 3: add the term, saturate, return to sign and magnitude
	always_comb begin
		logic signed [SUM_W-1:0] pm, tx, s, ns;
		pm = '0;
		tx = '0;
		s  = '0;
		ns = '0;
		for (int l = 0; l < LANES; l++) begin
			pm = $signed({{(SUM_W-PROD_W){1'b0}}, m_s2[l]});
			tx = SUM_W'(terms[l]);
			s  = neg_s2[l] ? (tx - pm) : (tx + pm);
			ns = neg_s2[l] ? (pm - tx) : (-tx - pm);
			if (s > INNER_MAX) begin
				acc_d[l].neg = 1'b0;
				acc_d[l].mag = MAG_MAX;
			end else if (s < INNER_MIN) begin
				acc_d[l].neg = 1'b1;
				acc_d[l].mag = MAG_LIMIT;
			end else begin
				acc_d[l].neg = s[SUM_W-1];
				acc_d[l].mag = s[SUM_W-1] ? ns[ACC_W-1:0] : s[ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && valid_s2) begin
			item_s3.t     <= t_s2;
			item_s3.phase <= phase_s2;
			for (int l = 0; l < LANES; l++) begin
				item_s3.acc[l] <= acc_d[l];
			end
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

	// Range checks on the stage registers
	always_comb begin
		caps_ok = 1'b1;
		mags_ok = 1'b1;
		for (int l = 0; l < LANES; l++) begin
			if (m_s2[l] > PROD_CAP) caps_ok = 1'b0;
			if (item_s3.acc[l].neg ? (item_s3.acc[l].mag > MAG_LIMIT)
				: (item_s3.acc[l].mag > MAG_MAX)) mags_ok = 1'b0;
		end
	end

	a_prod_capped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> caps_ok)
		else $error("product magnitude above cap");

	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> mags_ok)
		else $error("accumulator outside 56 bit range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_ready) |=> (valid_s3 && $stable(item_s3)))
		else $error("stalled step output changed");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for quintic_trajectory_evaluator: APB register programming,
// random sample traffic with stalls on both sides, and a cycle-free predictor.
// Depends on qte_pkg and the quintic_trajectory_evaluator RTL.

module tb_top;
	import qte_pkg::*;

	localparam int     PIPE_DEPTH = 17;
	localparam longint ACC_HI     = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint ACC_LO     = -ACC_HI - 1;
	localparam longint OUT_HI     = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint OUT_LO     = -OUT_HI - 1;
	localparam longint unsigned PRODUCT_CAP = 64'h0200_0000_0000_0000;
	localparam longint unsigned HIGH_LIMIT  = 64'h0000_0200_0000_0000;
	localparam longint unsigned DUR_MAX     = 64'h0000_0000_7FFF_FFFF;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic signed [COEF_W-1:0] pos;
		logic signed [COEF_W-1:0] vel;
		logic signed [COEF_W-1:0] accel;
		logic signed [COEF_W-1:0] jrk;
		logic [1:0]               ph;
	} motion_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                       psel         = 1'b0;
	logic                       penable      = 1'b0;
	logic                       pwrite       = 1'b0;
	logic [ADDR_W-1:0]          paddr        = '0;
	logic [DATA_W-1:0]          pwdata       = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample_time  = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [COEF_W-1:0]   position;
	logic signed [COEF_W-1:0]   velocity;
	logic signed [COEF_W-1:0]   acceleration;
	logic signed [COEF_W-1:0]   jerk;
	logic [1:0]                 phase;

	// Shadow of the register file, updated as each write completes
	longint          coef_reg [6];
	longint unsigned dur_reg;

	motion_t expected_motion [$];
	int      error_count      = 0;
	int      samples_accepted = 0;
	int      results_checked  = 0;
	int      settings_count   = 0;
	logic    idle_on          = 1'b1;
	int      stall_left       = 0;

	quintic_trajectory_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_time  (sample_time),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.position     (position),
		.velocity     (velocity),
		.acceleration (acceleration),
		.jerk         (jerk),
		.phase        (phase)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < 6; i++)
			coef_reg[i] = 0;
		dur_reg = 0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Q.32 accumulator times Q15.16 time, rounded half away from zero, magnitude capped
	function automatic longint scale_by_time(input longint a, input longint unsigned t);
		longint unsigned mag;
		longint unsigned high_part;
		longint unsigned m;
		mag = (a < 0) ? -a : a;
		high_part = (mag >> 32) * t;
		if (high_part >= HIGH_LIMIT) begin
			m = PRODUCT_CAP;
		end else begin
			m = (high_part << 16) + (((mag & 64'hFFFF_FFFF) * t + 64'h8000) >> 16);
			if (m > PRODUCT_CAP)
				m = PRODUCT_CAP;
		end
		return (a < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic motion_t predict_motion(input logic signed [SAMPLE_W-1:0] stamp);
		longint          ts;
		longint unsigned t;
		longint          acc;
		longint          factor;
		longint          term;
		longint          lane_out [LANES];
		int              j;
		motion_t         m;
		ts = stamp;
		// clamp time into [0, duration]
		if (ts >= longint'(dur_reg)) begin
			t = dur_reg;
			m.ph = PHASE_DONE;
		end else if (ts < 0) begin
			t = 0;
			m.ph = PHASE_BEFORE;
		end else begin
			t = ts;
			m.ph = PHASE_MOVING;
		end
		// lane l is the l-th derivative; Horner over c5 down to c(l)
		for (int l = 0; l < LANES; l++) begin
			acc = 0;
			for (int k = 0; k < 6 - l; k++) begin
				j = 5 - k;
				factor = 1;
				for (int d = 0; d < l; d++)
					factor = factor * (j - d);
				term = factor * coef_reg[j];
				if (k == 0)
					acc = clip(term, ACC_LO, ACC_HI);
				else
					acc = clip(scale_by_time(acc, t) + term, ACC_LO, ACC_HI);
			end
			lane_out[l] = clip(acc, OUT_LO, OUT_HI);
		end
		m.pos   = lane_out[LANE_POS][COEF_W-1:0];
		m.vel   = lane_out[LANE_VEL][COEF_W-1:0];
		m.accel = lane_out[LANE_ACC][COEF_W-1:0];
		m.jrk   = lane_out[LANE_JERK][COEF_W-1:0];
		return m;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic signed [63:0] got,
			input logic signed [63:0] want);
		error_count++;
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
	endtask

	// Retire result transfers against the oldest prediction, then queue new samples
	always @(posedge clk) begin : check_results
		motion_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("result with no sample pending, position", position, 0);
			end else begin
				want = expected_motion.pop_front();
				results_checked++;
				if (position !== want.pos)
					report_mismatch("position", position, want.pos);
				if (velocity !== want.vel)
					report_mismatch("velocity", velocity, want.vel);
				if (acceleration !== want.accel)
					report_mismatch("acceleration", acceleration, want.accel);
				if (jerk !== want.jrk)
					report_mismatch("jerk", jerk, want.jrk);
				if (phase !== want.ph)
					report_mismatch("phase", phase, want.ph);
			end
		end
		if (arst_n && sample_valid && !sample_stall) begin
			expected_motion.push_back(predict_motion(sample_time));
			samples_accepted++;
		end
	end

	// Stall the result side in random bursts, started only while idle_on is set
	always @(posedge clk) begin
		if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
			stall_left   <= $urandom_range(1, 3);
			result_stall <= 1'b1;
		end else if (stall_left > 1) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			stall_left   <= 0;
			result_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- drivers

	// Offer one sample and hold it until the transfer completes
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] stamp);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_time  <= stamp;
		do @(posedge clk); while (sample_stall);
	endtask

	// Drop valid and let the pipeline empty before touching registers
	task automatic settle_pipeline();
		sample_valid <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	// APB write: setup then access; fill unused upper bits with noise
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] noise;
		logic [DATA_W-1:0] bus;
		noise = {$urandom, $urandom};
		if (idx == REG_DURATION)
			bus = {noise[DATA_W-1:TIME_W], value[TIME_W-1:0]};
		else
			bus = {noise[DATA_W-1:COEF_W], value[COEF_W-1:0]};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << REG_SHIFT;
		pwdata  <= bus;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_C5)
			coef_reg[idx] = longint'($signed(bus[COEF_W-1:0]));
		else if (idx == REG_DURATION)
			dur_reg = bus[TIME_W-1:0];
	endtask

	task automatic program_motion(input longint c0, input longint c1, input longint c2,
			input longint c3, input longint c4, input longint c5, input longint unsigned dur);
		settle_pipeline();
		write_reg(REG_C0, c0);
		write_reg(REG_C1, c1);
		write_reg(REG_C2, c2);
		write_reg(REG_C3, c3);
		write_reg(REG_C4, c4);
		write_reg(REG_C5, c5);
		write_reg(REG_DURATION, dur);
		settings_count++;
	endtask

	function automatic longint to_q32(input real r);
		return longint'(r * 4294967296.0);
	endfunction

	function automatic real rand_span(input int span);
		return (real'($urandom_range(0, 2 * span * 1000)) - real'(span * 1000)) / 1000.0;
	endfunction

	// Minimum-jerk move with random start, distance, start speed and acceleration
	task automatic program_random_profile();
		longint unsigned dur;
		real             tr;
		real             travel;
		dur    = $urandom_range(32'h0001_0000, 32'h003C_0000);
		tr     = real'(dur) / 65536.0;
		travel = rand_span(1000);
		program_motion(to_q32(rand_span(1000)), to_q32(rand_span(10)),
			to_q32(rand_span(10) / 2.0), to_q32(10.0 * travel / (tr * tr * tr)),
			to_q32(-15.0 * travel / (tr * tr * tr * tr)),
			to_q32(6.0 * travel / (tr * tr * tr * tr * tr)), dur);
	endtask

	// Mostly inside the move, some before, some at or past the end
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input longint unsigned dur);
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return -SAMPLE_W'($urandom_range(1, 32'h0010_0000));
			2:       return SAMPLE_W'(dur + $urandom_range(0, 32'h0004_0000));
			3:       return SAMPLE_W'(dur);
			default: return $urandom_range(0, 32'(dur));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset leaves all coefficients and the duration at zero
	task automatic test_reset_state();
		settle_pipeline();
		settings_count++;
		send_sample(32'sh0000_0000);
		send_sample(32'shFFFF_FFFF);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sh0000_0001);
	endtask

	task automatic test_register_extremes();
		longint cmax;
		cmax = OUT_HI;
		// largest coefficients and longest duration: saturation at the far end
		program_motion(cmax, cmax, cmax, cmax, cmax, cmax, DUR_MAX);
		send_sample(32'sh0000_0000);
		send_sample(32'sh0000_0001);
		send_sample(32'sh7FFF_FFFE);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		// most negative coefficients
		program_motion(-cmax - 1, -cmax - 1, -cmax - 1, -cmax - 1, -cmax - 1, -cmax - 1,
			DUR_MAX);
		send_sample(32'sh4000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'shFFFF_FFFF);
		// zero duration pins time at zero; the spare address must not alias
		program_motion(to_q32(3.25), to_q32(-1.5), to_q32(0.75), to_q32(-2.0), to_q32(7.0),
			to_q32(-9.0), 0);
		write_reg(REG_SPARE, {$urandom, $urandom});
		send_sample(32'sh0000_0000);
		send_sample(32'sh0005_0000);
		send_sample(32'shFFFF_FFFF);
		// short move: step across the end of the interval, then back inside it
		program_motion(to_q32(-1.0), 48'sh0000_0000_0001, -48'sh0000_0000_0003,
			to_q32(1.25), to_q32(-0.5), 48'sh0000_0000_8001, 32'h0002_0000);
		send_sample(32'sh0001_FFFF);
		send_sample(32'sh0002_0000);
		send_sample(32'sh0002_0001);
		send_sample(32'sh0001_0000);
		send_sample(32'sh0000_8000);
	endtask

	task automatic test_motion_profiles();
		for (int p = 0; p < 8; p++) begin
			program_random_profile();
			for (int i = 0; i < 40; i++)
				send_sample(pick_sample(dur_reg));
		end
	endtask

	// Arbitrary register contents push the accumulators into saturation
	task automatic test_saturation();
		for (int p = 0; p < 2; p++) begin
			program_motion({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			for (int i = 0; i < 50; i++)
				send_sample(($urandom_range(0, 1) == 0) ? $urandom : pick_sample(dur_reg));
		end
	endtask

	// Full rate in both directions
	task automatic test_back_to_back();
		idle_on <= 1'b0;
		program_random_profile();
		for (int i = 0; i < 80; i++)
			send_sample(pick_sample(dur_reg));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_extremes();
		test_motion_profiles();
		test_saturation();
		test_back_to_back();
		settle_pipeline();
		$display("Evaluated %0d sample times over %0d register settings; %0d results compared.",
			samples_accepted, settings_count, results_checked);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", expected_motion.size());
		$display("simulation failed");
		$finish;
	end

endmodule
